>>> design/disjoint_set_union_find_macros.svh
`ifndef DISJOINT_SET_UNION_FIND_MACROS_SVH
`define DISJOINT_SET_UNION_FIND_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define DSUF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsuf: same-cycle check failed");

// next-cycle implication
`define DSUF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsuf: next-cycle check failed");

`endif

>>> design/dsuf_pkg.sv
package dsuf_pkg;

  localparam int MAX_ITEMS_DEF = 1024;
  localparam int ITEM_W        = 11;
  localparam int CNT_W         = 11;
  localparam int IN_DATA_W     = 24;
  localparam int OUT_DATA_W    = 16;
  localparam int STEP_W        = 3;

  // program steps
  localparam logic [STEP_W-1:0] S_CLR   = 3'd0;
  localparam logic [STEP_W-1:0] S_IDLE  = 3'd1;
  localparam logic [STEP_W-1:0] S_WALK1 = 3'd2;
  localparam logic [STEP_W-1:0] S_WALK2 = 3'd3;
  localparam logic [STEP_W-1:0] S_SIZE  = 3'd4;
  localparam logic [STEP_W-1:0] S_LINK  = 3'd5;
  localparam logic [STEP_W-1:0] S_OUT   = 3'd6;

  // hold conditions: stay on the current step while true
  localparam logic [2:0] H_NONE      = 3'd0;
  localparam logic [2:0] H_CLR_MORE  = 3'd1;
  localparam logic [2:0] H_NO_ACCEPT = 3'd2;
  localparam logic [2:0] H_PARENT    = 3'd3;
  localparam logic [2:0] H_OUT_BUSY  = 3'd4;

  // jump conditions: go to target instead of the next step
  localparam logic [1:0] J_NEVER  = 2'd0;
  localparam logic [1:0] J_ALWAYS = 2'd1;
  localparam logic [1:0] J_BAD    = 2'd2;
  localparam logic [1:0] J_END    = 2'd3;

  // read address source
  localparam logic RA_IN   = 1'b0;
  localparam logic RA_WALK = 1'b1;

  // write select
  localparam logic [1:0] WS_NONE = 2'd0;
  localparam logic [1:0] WS_CLR  = 2'd1;
  localparam logic [1:0] WS_SIZE = 2'd2;
  localparam logic [1:0] WS_LINK = 2'd3;

  typedef struct packed {
    logic [2:0]        hold;
    logic [1:0]        jump;
    logic [STEP_W-1:0] target;
    logic              ra_sel;
    logic [1:0]        ws;
    logic              in_ready;
    logic              ld_in;
    logic              walk;
    logic              ld_r1;
    logic              ld_r2;
    logic              inc_merge;
    logic              ld_out;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic bad;
    logic parent;
    logic walk_end;
    logic clr_last;
    logic out_busy;
  } stat_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '0;
    unique case (step)
      S_CLR: begin
        w.hold = H_CLR_MORE;
        w.ws   = WS_CLR;
      end
      S_IDLE: begin
        w.hold     = H_NO_ACCEPT;
        w.jump     = J_BAD;
        w.target   = S_OUT;
        w.ra_sel   = RA_IN;
        w.in_ready = 1'b1;
        w.ld_in    = 1'b1;
      end
      S_WALK1: begin
        w.hold   = H_PARENT;
        w.ra_sel = RA_WALK;
        w.walk   = 1'b1;
        w.ld_r1  = 1'b1;
      end
      S_WALK2: begin
        w.hold   = H_PARENT;
        w.jump   = J_END;
        w.target = S_OUT;
        w.ra_sel = RA_WALK;
        w.walk   = 1'b1;
        w.ld_r2  = 1'b1;
      end
      S_SIZE: begin
        w.ws        = WS_SIZE;
        w.inc_merge = 1'b1;
      end
      S_LINK: begin
        w.ws = WS_LINK;
      end
      S_OUT: begin
        w.hold   = H_OUT_BUSY;
        w.jump   = J_ALWAYS;
        w.target = S_IDLE;
        w.ld_out = 1'b1;
      end
      default: begin
        w.jump   = J_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> design/dsuf_ram.sv
module dsuf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/dsuf_seq.sv
module dsuf_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            restart,
  input  dsuf_pkg::stat_t stat,
  output dsuf_pkg::ctrl_t ctrl
);
  import dsuf_pkg::*;

  logic [STEP_W-1:0] pc_r, pc_nxt;
  logic              hold_hit, jump_hit;

  assign ctrl = ucode(pc_r);

  always_comb begin
    unique case (ctrl.hold)
      H_NONE:      hold_hit = 1'b0;
      H_CLR_MORE:  hold_hit = !stat.clr_last;
      H_NO_ACCEPT: hold_hit = !stat.accept;
      H_PARENT:    hold_hit = stat.parent;
      H_OUT_BUSY:  hold_hit = stat.out_busy;
      default:     hold_hit = 1'b0;
    endcase
    unique case (ctrl.jump)
      J_NEVER:  jump_hit = 1'b0;
      J_ALWAYS: jump_hit = 1'b1;
      J_BAD:    jump_hit = stat.bad;
      J_END:    jump_hit = stat.walk_end;
      default:  jump_hit = 1'b0;
    endcase
  end

  always_comb begin
    priority if (restart) begin
      pc_nxt = S_CLR;
    end else if (hold_hit) begin
      pc_nxt = pc_r;
    end else if (jump_hit) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = pc_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_CLR;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> design/dsuf_dp.sv
module dsuf_dp #(
  parameter int MAX_ITEMS = dsuf_pkg::MAX_ITEMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dsuf_pkg::ctrl_t                  ctrl,
  input  logic                             clear,
  input  logic [dsuf_pkg::CNT_W-1:0]       item_count,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dsuf_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dsuf_pkg::OUT_DATA_W-1:0]  out_tdata,
  output dsuf_pkg::stat_t                  stat
);
  import dsuf_pkg::*;

  localparam int ADDR_W  = $clog2(MAX_ITEMS);
  localparam int ENTRY_W = $clog2(MAX_ITEMS + 1) + 1;

  logic [ITEM_W-1:0]         in_first, in_second, rd_item, ra_item, wa_item;
  logic                      bad_in, parent, accept, big1;
  logic signed [ENTRY_W-1:0] rd_data, wdata;
  logic [ADDR_W-1:0]         raddr, waddr;
  logic                      we;

  logic [ITEM_W-1:0]         cur_r, b_r, r1_r, r2_r;
  logic signed [ENTRY_W-1:0] v1_r, v2_r;
  logic                      func_r, bad_r, conn_r;
  logic [CNT_W-1:0]          merge_r, merge_nxt;
  logic [ADDR_W-1:0]         clr_ptr_r, clr_ptr_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]     out_data_r;
  logic [CNT_W-1:0]          components;

  assign in_first  = in_tdata[ITEM_W-1:0];
  assign in_second = in_tdata[2*ITEM_W-1:ITEM_W];
  assign in_tready = ctrl.in_ready;
  assign accept    = in_tvalid && in_tready;

  assign bad_in = (in_first == '0) || (in_second == '0) ||
                  (in_first > item_count) || (in_second > item_count);

  // a nonnegative entry is a parent link, a negative one a root size
  assign parent  = !rd_data[ENTRY_W-1];
  assign rd_item = ITEM_W'($unsigned(rd_data));

  always_comb begin
    if (ctrl.ra_sel == RA_IN) begin
      ra_item = in_first;
    end else if (parent) begin
      ra_item = rd_item;
    end else begin
      ra_item = b_r;
    end
  end
  assign raddr = ADDR_W'(ra_item - ITEM_W'(1));

  // the root of the strictly larger set (more negative entry) absorbs the other
  assign big1 = v1_r < v2_r;

  always_comb begin
    we      = 1'b0;
    wa_item = r1_r;
    wdata   = v1_r + v2_r;
    waddr   = ADDR_W'(wa_item - ITEM_W'(1));
    unique case (ctrl.ws)
      WS_NONE: begin
        we = 1'b0;
      end
      WS_CLR: begin
        we    = 1'b1;
        waddr = clr_ptr_r;
        wdata = {ENTRY_W{1'b1}};
      end
      WS_SIZE: begin
        we      = 1'b1;
        wa_item = big1 ? r1_r : r2_r;
        waddr   = ADDR_W'(wa_item - ITEM_W'(1));
        wdata   = v1_r + v2_r;
      end
      WS_LINK: begin
        we      = 1'b1;
        wa_item = big1 ? r2_r : r1_r;
        waddr   = ADDR_W'(wa_item - ITEM_W'(1));
        wdata   = big1 ? ENTRY_W'(r1_r) : ENTRY_W'(r2_r);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  dsuf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ITEMS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (ctrl.ld_in && accept) begin
      func_r <= in_tuser;
      b_r    <= in_second;
      cur_r  <= in_first;
      bad_r  <= bad_in;
      conn_r <= 1'b0;
    end
    if (ctrl.walk) begin
      cur_r <= parent ? rd_item : b_r;
    end
    if (ctrl.ld_r1 && !parent) begin
      r1_r <= cur_r;
      v1_r <= rd_data;
    end
    if (ctrl.ld_r2 && !parent) begin
      r2_r   <= cur_r;
      v2_r   <= rd_data;
      conn_r <= cur_r == r1_r;
    end
  end

  assign components = item_count - merge_r;

  always_comb begin
    merge_nxt = merge_r;
    if (clear) begin
      merge_nxt = '0;
    end else if (ctrl.inc_merge) begin
      merge_nxt = merge_r + CNT_W'(1);
    end
    clr_ptr_nxt = clr_ptr_r;
    if (clear) begin
      clr_ptr_nxt = '0;
    end else if (ctrl.ws == WS_CLR) begin
      clr_ptr_nxt = clr_ptr_r + ADDR_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (ctrl.ld_out && !stat.out_busy) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      merge_r     <= '0;
      clr_ptr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      merge_r     <= merge_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_out && !stat.out_busy) begin
      out_data_r <= {(OUT_DATA_W - CNT_W - 2)'(0), bad_r, components, conn_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign stat.accept   = accept;
  assign stat.bad      = bad_in;
  assign stat.parent   = parent;
  assign stat.walk_end = (cur_r == r1_r) || func_r;
  assign stat.clr_last = clr_ptr_r == ADDR_W'(MAX_ITEMS - 1);
  assign stat.out_busy = out_valid_r && !out_tready;

endmodule

>>> design/disjoint_set_union_find.sv
// each accepted word walks up from the first item to its root, then from the second,
// one table read per link; a union of two different roots then writes the merged size
// and the link, while func set or one shared root skips those writes and a bad number
// skips the walks too; the next word is taken only once the result is loaded for output
// reset (rst_n low, synchronous) and every cfg write start a clearing pass that sets all
// entries back to singleton roots; in_tready stays low meanwhile
module disjoint_set_union_find #(
  parameter int MAX_ITEMS = dsuf_pkg::MAX_ITEMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [dsuf_pkg::CNT_W-1:0]       cfg_wr_data,  // item_count
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dsuf_pkg::IN_DATA_W-1:0]   in_tdata,     // first_item, second_item, zero pad
  input  logic                             in_tuser,     // func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dsuf_pkg::OUT_DATA_W-1:0]  out_tdata     // connected, components, bad_index, pad
);
  import dsuf_pkg::*;

  localparam int CNT_TOP = (MAX_ITEMS < (1 << CNT_W)) ? MAX_ITEMS : (1 << CNT_W) - 1;

  logic [CNT_W-1:0] item_count_r, item_count_nxt;
  ctrl_t            ctrl;
  stat_t            stat;

  // saturate the requested count into 1..CNT_TOP
  always_comb begin
    item_count_nxt = item_count_r;
    if (cfg_wr_en) begin
      priority if (cfg_wr_data == '0) begin
        item_count_nxt = CNT_W'(1);
      end else if (32'(cfg_wr_data) > CNT_TOP) begin
        item_count_nxt = CNT_W'(CNT_TOP);
      end else begin
        item_count_nxt = cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r <= CNT_W'(CNT_TOP);
    end else begin
      item_count_r <= item_count_nxt;
    end
  end

  dsuf_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_wr_en),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  dsuf_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .clear      (cfg_wr_en),
    .item_count (item_count_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .stat       (stat)
  );

endmodule

>>> design/dsuf_chk.sv
`include "disjoint_set_union_find_macros.svh"

module dsuf_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             cfg_wr_en,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [dsuf_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // a stalled result stays offered
  `DSUF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)

  // one word at a time: input closes right after an accept
  `DSUF_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)

  // a register write starts the clearing pass
  `DSUF_ASSERT_NEXT(a_cfg_clears, cfg_wr_en, !in_tready)

  // there is always at least one component
  `DSUF_ASSERT_NOW(a_comp_nonzero, out_tvalid, out_tdata[11:1] != 11'd0)

  // a rejected request never reports a connection
  `DSUF_ASSERT_NOW(a_bad_unconn, out_tvalid && out_tdata[12], !out_tdata[0])

endmodule

bind disjoint_set_union_find dsuf_chk u_dsuf_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_wr_en  (cfg_wr_en),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
